[rtl/core/cartesian_polar_converter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Cartesian/polar converter assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_POLAR_CONVERTER_UNIT_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge
`define CPC_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cpc assertion failed");
// antecedent at one edge implies consequent at the next edge
`define CPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpc assertion failed");
`else
`define CPC_ASSERT_ALWAYS(name, cond)
`define CPC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[rtl/core/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the Cartesian/polar CORDIC converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_CART  = 1'b1
  } cpc_op_t;

  // travels alongside the datapath through every stage
  typedef struct packed {
    logic    valid;
    cpc_op_t mode;
    logic    zero;
  } cpc_side_t;

  localparam int GUARD       = 14;  // fraction bits added to the coordinates
  localparam int GROWTH_BITS = 3;   // sign plus CORDIC gain headroom
  localparam int TAB_LEN     = 24;

  // gain correction K = KGAIN / 2^30
  localparam int          KGAIN_W    = 30;
  localparam logic [29:0] KGAIN      = 30'd652032874;
  localparam int          LO_W       = 16;
  localparam int          PROD_SHIFT = GUARD + KGAIN_W;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in 2^32 units per circle
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

[rtl/core/cartesian_polar_converter_unit.sv]
// ----------------------------------------------------------------------------
// cartesian_polar_converter_unit
// Pipelined CORDIC converter between Cartesian and polar vector form.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_operation selects the direction.
//   To polar: in_x, in_y give out_radius and out_angle (out_x, out_y are 0).
//   To Cartesian: in_radius, in_angle give out_x, out_y (radius, angle are 0).
// Angles are binary: 65536 units per circle, -32768 stands for -pi.
// Result channel (out_valid/out_ready) carries one item per input item, in
// order.
// Stages from accept to out_valid: one input fold stage, one cell per
// micro-rotation, one gain multiply stage and the output register.
// Throughput: one item per cycle unless the receiver stalls; every
// micro-rotation has its own cell.
// When the receiver stalls, a two-entry output register/skid pair absorbs
// the item in flight, then the whole chain freezes and in_ready drops;
// in_ready comes from a register only.
// Reset (rst_n low, synchronous) empties the chain and the output stage;
// there is no other state.
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_unit_assert.svh"

module cartesian_polar_converter_unit #(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpc_pkg::cpc_op_t              in_operation,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH:0]   in_radius,
  input  logic signed [15:0]            in_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH:0]   out_x,
  output logic signed [COORD_WIDTH:0]   out_y,
  output logic [COORD_WIDTH-1:0]        out_radius,
  output logic signed [15:0]            out_angle
);
  import cpc_pkg::*;

  localparam int XW = COORD_WIDTH + GUARD + GROWTH_BITS;
  localparam int GW = XW - LO_W + KGAIN_W + 2 - (PROD_SHIFT - LO_W);

  cpc_side_t            side_c [ITERATIONS+1];
  logic signed [XW-1:0] x_c    [ITERATIONS+1];
  logic signed [XW-1:0] y_c    [ITERATIONS+1];
  logic [31:0]          z_c    [ITERATIONS+1];

  cpc_side_t            side_g_r;
  logic [15:0]          ang_g_r;
  logic signed [GW-1:0] gx, gy;

  logic                          en, take, arrive;
  logic                          out_valid_r, skid_valid_r;
  logic signed [COORD_WIDTH:0]   res_x, res_y, out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic [COORD_WIDTH-1:0]        res_r, out_r_r, skid_r_r;
  logic [15:0]                   res_a, out_a_r, skid_a_r;
  logic [COORD_WIDTH-1:0]        clamp_r;
  logic signed [COORD_WIDTH:0]   clamp_x, clamp_y;

  // chain advances unless an item already waits in the skid register
  assign en       = !skid_valid_r;
  assign in_ready = en;

  cpc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .operation (in_operation),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_radius (in_radius),
    .in_angle  (in_angle),
    .side_r    (side_c[0]),
    .x_r       (x_c[0]),
    .y_r       (y_c[0]),
    .z_r       (z_c[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    cpc_cell #(
      .XW    (XW),
      .STAGE (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side_c[k]),
      .x_i    (x_c[k]),
      .y_i    (y_c[k]),
      .z_i    (z_c[k]),
      .side_r (side_c[k+1]),
      .x_r    (x_c[k+1]),
      .y_r    (y_c[k+1]),
      .z_r    (z_c[k+1])
    );
  end

  cpc_gain #(.VW(XW)) u_gain_x (
    .clk (clk),
    .en  (en),
    .v_i (x_c[ITERATIONS]),
    .res (gx)
  );

  cpc_gain #(.VW(XW)) u_gain_y (
    .clk (clk),
    .en  (en),
    .v_i (y_c[ITERATIONS]),
    .res (gy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_g_r <= '0;
    end else if (en) begin
      side_g_r <= side_c[ITERATIONS];
    end
  end

  // angle rounded to 16 bits, ties upward, with wrap-around
  always_ff @(posedge clk) begin
    if (en) begin
      ang_g_r <= 16'((z_c[ITERATIONS] + 32'h0000_8000) >> 16);
    end
  end

  // saturation and direction select
  always_comb begin
    if (gx[GW-1]) begin
      clamp_r = '0;
    end else if (gx[GW-2:COORD_WIDTH] != '0) begin
      clamp_r = '1;
    end else begin
      clamp_r = gx[COORD_WIDTH-1:0];
    end

    if ((gx[GW-1:COORD_WIDTH] == '0) || (gx[GW-1:COORD_WIDTH] == '1)) begin
      clamp_x = gx[COORD_WIDTH:0];
    end else begin
      clamp_x = gx[GW-1] ? {1'b1, {COORD_WIDTH{1'b0}}} : {1'b0, {COORD_WIDTH{1'b1}}};
    end

    if ((gy[GW-1:COORD_WIDTH] == '0) || (gy[GW-1:COORD_WIDTH] == '1)) begin
      clamp_y = gy[COORD_WIDTH:0];
    end else begin
      clamp_y = gy[GW-1] ? {1'b1, {COORD_WIDTH{1'b0}}} : {1'b0, {COORD_WIDTH{1'b1}}};
    end

    unique case (side_g_r.mode)
      OP_TO_POLAR: begin
        res_x = '0;
        res_y = '0;
        res_r = side_g_r.zero ? '0 : clamp_r;
        res_a = side_g_r.zero ? '0 : ang_g_r;
      end
      OP_TO_CART: begin
        res_x = clamp_x;
        res_y = clamp_y;
        res_r = '0;
        res_a = '0;
      end
      default: begin
        res_x = '0;
        res_y = '0;
        res_r = '0;
        res_a = '0;
      end
    endcase
  end

  // output register with skid entry
  assign take   = out_valid_r && out_ready;
  assign arrive = en && side_g_r.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_x_r <= skid_x_r;
        out_y_r <= skid_y_r;
        out_r_r <= skid_r_r;
        out_a_r <= skid_a_r;
      end else begin
        out_x_r <= res_x;
        out_y_r <= res_y;
        out_r_r <= res_r;
        out_a_r <= res_a;
      end
    end else if (arrive) begin
      skid_x_r <= res_x;
      skid_y_r <= res_y;
      skid_r_r <= res_r;
      skid_a_r <= res_a;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_radius = out_r_r;
  assign out_angle  = out_a_r;

  `CPC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `CPC_ASSERT_NEXT(a_skid_holds, skid_valid_r && !out_ready, skid_valid_r && out_valid_r)
  `CPC_ASSERT_ALWAYS(a_one_direction, !out_valid_r || (out_x_r == '0 && out_y_r == '0) || (out_r_r == '0 && out_a_r == '0))

endmodule

[rtl/core/cpc_front.sv]
// ----------------------------------------------------------------------------
// cpc_front
// Input stage: half-plane fold, radius sign fold and scaling into CORDIC format.
// ----------------------------------------------------------------------------
module cpc_front #(
  parameter  int COORD_WIDTH = 16,
  localparam int XW = COORD_WIDTH + cpc_pkg::GUARD + cpc_pkg::GROWTH_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  cpc_pkg::cpc_op_t              operation,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH:0]   in_radius,
  input  logic signed [15:0]            in_angle,
  output cpc_pkg::cpc_side_t            side_r,
  output logic signed [XW-1:0]          x_r,
  output logic signed [XW-1:0]          y_r,
  output logic [31:0]                   z_r
);
  import cpc_pkg::*;

  logic signed [COORD_WIDTH:0]   xs, ys, xn, yn;
  logic signed [COORD_WIDTH+1:0] rs, rn;
  logic signed [XW-1:0]          xp, yp, rp;
  logic signed [XW-1:0]          x_nxt, y_nxt;
  logic [31:0]                   z_nxt, za;
  logic [15:0]                   a_adj;
  logic                          x_neg, r_neg, flip;
  cpc_side_t                     side_nxt;

  always_comb begin
    x_neg = in_x[COORD_WIDTH-1];
    xs    = {in_x[COORD_WIDTH-1], in_x};
    ys    = {in_y[COORD_WIDTH-1], in_y};
    xn    = x_neg ? -xs : xs;
    yn    = x_neg ? -ys : ys;

    r_neg = in_radius[COORD_WIDTH];
    rs    = {in_radius[COORD_WIDTH], in_radius};
    rn    = r_neg ? -rs : rs;
    // negative radius: add half a circle, i.e. flip the top angle bit
    a_adj = in_angle ^ {r_neg, 15'b0};
    za    = {a_adj, 16'h0000};
    // angle beyond +/- a quarter turn: start from the opposite half plane
    flip  = (za[31:30] == 2'b01 && za[29:0] != '0) || (za[31:30] == 2'b10);

    xp = {{(XW-COORD_WIDTH-1-GUARD){xn[COORD_WIDTH]}}, xn, {GUARD{1'b0}}};
    yp = {{(XW-COORD_WIDTH-1-GUARD){yn[COORD_WIDTH]}}, yn, {GUARD{1'b0}}};
    rp = {{(XW-COORD_WIDTH-2-GUARD){rn[COORD_WIDTH+1]}}, rn, {GUARD{1'b0}}};

    side_nxt.valid = in_valid;
    side_nxt.mode  = operation;
    unique case (operation)
      OP_TO_POLAR: begin
        x_nxt         = xp;
        y_nxt         = yp;
        z_nxt         = x_neg ? HALF_TURN : '0;
        side_nxt.zero = (in_x == '0) && (in_y == '0);
      end
      OP_TO_CART: begin
        x_nxt         = flip ? -rp : rp;
        y_nxt         = '0;
        z_nxt         = flip ? za + HALF_TURN : za;
        side_nxt.zero = 1'b0;
      end
      default: begin
        x_nxt         = '0;
        y_nxt         = '0;
        z_nxt         = '0;
        side_nxt.zero = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

[rtl/core/cpc_cell.sv]
// ----------------------------------------------------------------------------
// cpc_cell
// One CORDIC micro-rotation, registered; vectoring or rotation per item.
// ----------------------------------------------------------------------------
module cpc_cell #(
  parameter int XW    = 33,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cpc_pkg::cpc_side_t   side_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          z_i,
  output cpc_pkg::cpc_side_t   side_r,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic [31:0]          z_r
);
  import cpc_pkg::*;

  localparam logic [31:0] ATAN_STEP = ATAN_TAB[STAGE];

  logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
  logic [31:0]          z_nxt;
  logic                 y_pos, ccw;

  always_comb begin
    dx    = y_i >>> STAGE;
    dy    = x_i >>> STAGE;
    y_pos = !y_i[XW-1] && (y_i != '0);
    // rotation drives z to zero, vectoring drives y to zero
    ccw   = (side_i.mode == OP_TO_CART) ? !z_i[31] : !y_pos;
    if (ccw) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN_STEP;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

[rtl/core/cpc_gain.sv]
// ----------------------------------------------------------------------------
// cpc_gain
// CORDIC gain correction: v * KGAIN / 2^44 rounded to nearest, ties upward.
// The operand is split into a low 16-bit slice and a high slice whose products
// are registered, then summed and shifted in the following cycle.
// ----------------------------------------------------------------------------
module cpc_gain #(
  parameter  int VW  = 33,
  localparam int PHW = VW - cpc_pkg::LO_W + cpc_pkg::KGAIN_W + 1,
  localparam int RW  = PHW + 1 - (cpc_pkg::PROD_SHIFT - cpc_pkg::LO_W)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] v_i,
  output logic signed [RW-1:0] res
);
  import cpc_pkg::*;

  localparam int PLW = LO_W + KGAIN_W + 1;

  logic signed [VW-LO_W-1:0] hi;
  logic [LO_W-1:0]           lo;
  logic [PLW-1:0]            pl_nxt, pl_r;
  logic signed [PHW-1:0]     ph_nxt, ph_r;
  logic signed [PHW:0]       sum;

  always_comb begin
    hi     = v_i[VW-1:LO_W];
    lo     = v_i[LO_W-1:0];
    pl_nxt = PLW'(lo) * PLW'(KGAIN) + (PLW'(1) << (PROD_SHIFT - 1));
    ph_nxt = PHW'(hi) * PHW'($signed({1'b0, KGAIN}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    sum = $signed({ph_r[PHW-1], ph_r})
        + $signed({{(PHW+1-(PLW-LO_W)){1'b0}}, pl_r[PLW-1:LO_W]});
    res = sum[PHW:PROD_SHIFT-LO_W];
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Cartesian/polar converter testbench
// Drives both conversion directions through the valid/ready input channel,
// predicts every result with a bit-exact CORDIC model held in a scoreboard
// and checks the results in order, with random gaps and stalls on both
// sides and one long output stall that backs up the whole pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import cpc_pkg::*;

  localparam int     CORDIC_STEPS = 16;
  localparam int     CW           = 16;
  localparam int     PIPE_LATENCY = CORDIC_STEPS + 3;
  localparam int     RANDOM_ITEMS = 1100;
  localparam int     LONG_STALL   = 150;
  localparam longint GAIN         = longint'(KGAIN);
  localparam int     QUARTER      = 32'h4000_0000;

  typedef struct packed {
    logic signed [CW:0]   x;
    logic signed [CW:0]   y;
    logic [CW-1:0]        radius;
    logic signed [15:0]   angle;
  } vec_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cpc_op_t              in_operation = OP_TO_POLAR;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic signed [CW:0]   in_radius = '0;
  logic signed [15:0]   in_angle = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW:0]   out_x;
  logic signed [CW:0]   out_y;
  logic [CW-1:0]        out_radius;
  logic signed [15:0]   out_angle;

  logic long_hold_req = 1'b0;
  int   held_off_cycles = 0;

  cartesian_polar_converter_unit #(
    .ITERATIONS (CORDIC_STEPS),
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_radius   (in_radius),
    .in_angle    (in_angle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_radius  (out_radius),
    .out_angle   (out_angle)
  );

  always #5 clk = ~clk;

  class conversion_checker;
    vec_result_t awaited[$];
    int errors = 0;
    int matched = 0;
    int to_polar_cnt = 0;
    int to_cart_cnt = 0;

    task report(string msg);
      errors++;
      if (errors <= 60) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // round(v * GAIN / 2^44), ties upward
    function longint scale_gain(longint v);
      return (v * GAIN + (longint'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    endfunction

    function vec_result_t cordic_convert(cpc_op_t op, logic signed [CW-1:0] cx,
                                         logic signed [CW-1:0] cy,
                                         logic signed [CW:0] rad,
                                         logic signed [15:0] ang);
      vec_result_t res;
      longint      vx, vy, dx, dy, r, prod, lim;
      bit [31:0]   z;
      bit [15:0]   a;
      int          sz;
      res = '0;
      lim = longint'(1) <<< CW;
      if (op == OP_TO_POLAR) begin
        vx = cx;
        vy = cy;
        if (vx == 0 && vy == 0) return res;
        z = '0;
        // fold the left half plane onto the right one
        if (vx < 0) begin
          vx = -vx;
          vy = -vy;
          z = HALF_TURN;
        end
        vx = vx <<< GUARD;
        vy = vy <<< GUARD;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          if (vy > 0) begin
            vx += dx;
            vy -= dy;
            z += ATAN_TAB[i];
          end else begin
            vx -= dx;
            vy += dy;
            z -= ATAN_TAB[i];
          end
        end
        prod = scale_gain(vx);
        if (prod < 0) prod = 0;
        if (prod > lim - 1) prod = lim - 1;
        res.radius = prod[CW-1:0];
        z = z + 32'h0000_8000;
        res.angle = z[31:16];
      end else begin
        r = rad;
        a = ang;
        if (r < 0) begin
          r = -r;
          a = a + 16'h8000;
        end
        z = {a, 16'h0000};
        vx = r <<< GUARD;
        vy = 0;
        sz = $signed(z);
        if (sz > QUARTER || sz < -QUARTER) begin
          vx = -vx;
          z = z + HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          sz = $signed(z);
          if (sz >= 0) begin
            vx -= dx;
            vy += dy;
            z -= ATAN_TAB[i];
          end else begin
            vx += dx;
            vy -= dy;
            z += ATAN_TAB[i];
          end
        end
        prod = scale_gain(vx);
        if (prod < -lim) prod = -lim;
        if (prod > lim - 1) prod = lim - 1;
        res.x = prod[CW:0];
        prod = scale_gain(vy);
        if (prod < -lim) prod = -lim;
        if (prod > lim - 1) prod = lim - 1;
        res.y = prod[CW:0];
      end
      return res;
    endfunction

    function void note_input(cpc_op_t op, logic signed [CW-1:0] cx,
                             logic signed [CW-1:0] cy, logic signed [CW:0] rad,
                             logic signed [15:0] ang);
      awaited.push_back(cordic_convert(op, cx, cy, rad, ang));
      if (op == OP_TO_POLAR) to_polar_cnt++;
      else to_cart_cnt++;
    endfunction

    task check_result(vec_result_t got);
      vec_result_t exp;
      string       bad;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: x=%0d y=%0d r=%0d a=%0d",
                         got.x, got.y, got.radius, got.angle));
        return;
      end
      exp = awaited.pop_front();
      bad = "";
      if (got.x !== exp.x) bad = {bad, " x"};
      if (got.y !== exp.y) bad = {bad, " y"};
      if (got.radius !== exp.radius) bad = {bad, " radius"};
      if (got.angle !== exp.angle) bad = {bad, " angle"};
      if (bad != "") begin
        report($sformatf("wrong%s: got x=%0d y=%0d r=%0d a=%0d, want x=%0d y=%0d r=%0d a=%0d",
                         bad, got.x, got.y, got.radius, got.angle,
                         exp.x, exp.y, exp.radius, exp.angle));
      end else begin
        matched++;
      end
    endtask
  endclass

  conversion_checker checker_h = new();

  // mostly short gaps, now and then a long one
  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2: return CW'($urandom_range(0, 16) - 8);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CW:0] pick_radius();
    case ($urandom_range(0, 15))
      0: return (CW + 1)'($urandom);
      1: return (CW + 1)'($urandom_range(0, 2) * 46341 - 46341);
      2: return (CW + 1)'($urandom_range(0, 16) - 8);
      default: return (CW + 1)'($urandom_range(0, 92682) - 46341);
    endcase
  endfunction

  task automatic send_item(cpc_op_t op, logic signed [CW-1:0] cx,
                           logic signed [CW-1:0] cy, logic signed [CW:0] rad,
                           logic signed [15:0] ang, int gap);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_x         <= cx;
    in_y         <= cy;
    in_radius    <= rad;
    in_angle     <= ang;
    do @(posedge clk); while (!in_ready);
    checker_h.note_input(op, cx, cy, rad, ang);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (checker_h.awaited.size() != 0);
  endtask

  // result side: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int  hold;
    bit  long_done;
    hold = 0;
    long_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) checker_h.check_result({out_x, out_y, out_radius, out_angle});
      if (in_valid && !in_ready) held_off_cycles++;
      if (long_hold_req && !long_done) begin
        hold = LONG_STALL;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = idle_len(((checker_h.matched / 90) % 3) == 1);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // to polar: zero vector, axes, corners, the half-circle angle
    send_item(OP_TO_POLAR, 0, 0, 17'sh0ABCD, 16'sh1234, idle_len(0));
    send_item(OP_TO_POLAR, 32767, 0, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, -32768, 0, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, -5, 0, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 0, 32767, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 0, -32768, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 32767, 32767, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, -32768, -32768, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, -32768, 32767, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 32767, -32768, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 1, 0, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, -1, -1, 0, 0, idle_len(0));
    send_item(OP_TO_POLAR, 1, -1, -17'sd1, -16'sd1, idle_len(0));
    // to Cartesian: zero and largest radius, negative radius, saturation
    send_item(OP_TO_CART, 16'sh7FFF, 16'sh8000, 0, 16'sh4321, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 46341, 0, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 46341, -32768, idle_len(0));
    send_item(OP_TO_CART, 0, 0, -46341, 16384, idle_len(0));
    send_item(OP_TO_CART, 0, 0, -65536, 0, idle_len(0));
    send_item(OP_TO_CART, 0, 0, -65536, 8192, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 65535, 8192, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 1, 32767, idle_len(0));
    send_item(OP_TO_CART, 0, 0, -1, -32768, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 46341, -16384, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 1000, 16384, idle_len(0));
    send_item(OP_TO_CART, 0, 0, 1000, -16385, idle_len(0));

    wait_all_results();

    // back-to-back items against a long output stall
    long_hold_req <= 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_item(cpc_op_t'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                pick_radius(), 16'($urandom), 0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(cpc_op_t'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                pick_radius(), 16'($urandom), idle_len(((n / 100) % 3) == 2));
    end

    wait_all_results();
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (checker_h.awaited.size() != 0)
      checker_h.report($sformatf("%0d results never came", checker_h.awaited.size()));
    $display("Converted %0d vectors to polar and %0d to Cartesian, %0d results matched.",
             checker_h.to_polar_cnt, checker_h.to_cart_cnt, checker_h.matched);
    $display("Input held off for %0d cycles by output stalls, %0d mismatches.",
             held_off_cycles, checker_h.errors);
    if (checker_h.errors == 0 && checker_h.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: run did not complete");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[cartesian_polar_converter_unit.f]
+incdir+rtl/core
rtl/core/cpc_pkg.sv
rtl/core/cpc_front.sv
rtl/core/cpc_cell.sv
rtl/core/cpc_gain.sv
rtl/core/cartesian_polar_converter_unit.sv
verif/testbench.sv
